[hw/rtl/rrts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants
// Event codes, slot state codes, result status codes, controller commands.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int GRP_W     = 8;   // slots per first-level search group

    // event codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_BLOCK   = 3'd2;
    localparam logic [2:0] CMD_EXIT    = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK = 3'd4;

    // slot states
    localparam logic [2:0] ST_EMPTY      = 3'd0;
    localparam logic [2:0] ST_READY      = 3'd1;
    localparam logic [2:0] ST_RUNNING    = 3'd2;
    localparam logic [2:0] ST_WAITING    = 3'd3;
    localparam logic [2:0] ST_TERMINATED = 3'd4;

    // result status
    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_IGNORED    = 2'd2;
    localparam logic [1:0] STATUS_NONE_READY = 2'd3;

    typedef struct packed {
        logic capture;  // latch the incoming word
        logic commit;   // apply the update and load the result register
    } rrts_cmd_t;

    // lowest set bit of an 8-bit group: {any, index}
    function automatic logic [3:0] first8(input logic [7:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int k = GRP_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = {1'b1, 3'(k)};
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/rrts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl: scheduler controller
// Two-state sequencer: take a word, then commit it once the result register
// is free. Owns both handshakes.
// ----------------------------------------------------------------------------
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output rrts_cmd_t ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl.capture    = 1'b0;
        ctl.commit     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ctl.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/rrts_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp: scheduler datapath
// Slot state cells, current slot, two-level registered priority search
// (per-group first hit, then group select) and the result register.
// ----------------------------------------------------------------------------
module rrts_dp
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rrts_cmd_t  ctl,
    input  logic [2:0] cmd,
    input  logic [3:0] task_slot,
    output logic [3:0] current_slot,
    output logic [3:0] new_slot,
    output logic [1:0] status
);

    localparam int SW = $clog2(SLOTS);
    localparam int NG = (SLOTS + GRP_W - 1) / GRP_W;
    localparam int PW = NG * GRP_W;

    logic [2:0]    slot_reg [SLOTS];
    logic [2:0]    slot_next [SLOTS];
    logic [SW-1:0] cur_reg, cur_next;
    logic [2:0]    cmd_reg;
    logic [3:0]    tslot_reg;

    logic [SW-1:0] cur_out_next;

    // per-slot flags
    logic [PW-1:0] cand_v, hi_v, empty_v;
    logic [SLOTS-1:0] cur_oh, running_v;
    logic [15:0]   wait16;

    // first-level search results
    logic       hi_any_reg  [NG];
    logic [2:0] hi_idx_reg  [NG];
    logic       all_any_reg [NG];
    logic [2:0] all_idx_reg [NG];
    logic       emp_any_reg [NG];
    logic [2:0] emp_idx_reg [NG];

    logic          hi_found, all_found, emp_found, run_found;
    logic [SW-1:0] hi_sel, all_sel, emp_sel, run_sel;
    logic          cur_running;
    logic          unblock_ok;

    logic [3:0] new_slot_reg, new_slot_next;
    logic [3:0] cur_slot_reg, cur_slot_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        cand_v  = '0;
        hi_v    = '0;
        empty_v = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            cur_oh[i]    = (cur_reg == SW'(i));
            running_v[i] = (slot_reg[i] == ST_RUNNING);
            // current running task goes back to ready before the search
            cand_v[i]    = (slot_reg[i] == ST_READY) || (cur_oh[i] && running_v[i]);
            hi_v[i]      = cand_v[i] && (SW'(i) > cur_reg);
            empty_v[i]   = (slot_reg[i] == ST_EMPTY);
        end
        for (int k = 0; k < 16; k++)
        begin
            wait16[k] = 1'b0;
            if (k < SLOTS)
            begin
                wait16[k] = (slot_reg[k] == ST_WAITING);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            {hi_any_reg[g],  hi_idx_reg[g]}  <= first8(hi_v[g*GRP_W +: GRP_W]);
            {all_any_reg[g], all_idx_reg[g]} <= first8(cand_v[g*GRP_W +: GRP_W]);
            {emp_any_reg[g], emp_idx_reg[g]} <= first8(empty_v[g*GRP_W +: GRP_W]);
        end
    end

    // second level: lowest group with a hit
    always_comb
    begin
        hi_found  = 1'b0;
        all_found = 1'b0;
        emp_found = 1'b0;
        hi_sel    = '0;
        all_sel   = '0;
        emp_sel   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (hi_any_reg[g])
            begin
                hi_found = 1'b1;
                hi_sel   = SW'(g * GRP_W + int'(hi_idx_reg[g]));
            end
            if (all_any_reg[g])
            begin
                all_found = 1'b1;
                all_sel   = SW'(g * GRP_W + int'(all_idx_reg[g]));
            end
            if (emp_any_reg[g])
            begin
                emp_found = 1'b1;
                emp_sel   = SW'(g * GRP_W + int'(emp_idx_reg[g]));
            end
        end
        run_found = hi_found || all_found;
        run_sel   = hi_found ? hi_sel : all_sel;
    end

    assign cur_running = |(cur_oh & running_v);
    assign unblock_ok  = wait16[tslot_reg];

    always_comb
    begin
        cur_next      = cur_reg;
        new_slot_next = 4'd0;
        status_next   = STATUS_DONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        unique case (cmd_reg)
            CMD_TICK:
            begin
                if (run_found)
                begin
                    cur_next = run_sel;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (SW'(i) == run_sel)
                        begin
                            slot_next[i] = ST_RUNNING;
                        end
                        else if (cur_oh[i] && cur_running)
                        begin
                            slot_next[i] = ST_READY;
                        end
                    end
                end
                else
                begin
                    status_next = STATUS_NONE_READY;
                end
            end
            CMD_CREATE:
            begin
                if (emp_found)
                begin
                    new_slot_next = 4'(emp_sel);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (SW'(i) == emp_sel)
                        begin
                            slot_next[i] = ST_READY;
                        end
                    end
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            CMD_BLOCK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (cur_oh[i])
                    begin
                        slot_next[i] = ST_WAITING;
                    end
                end
            end
            CMD_EXIT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (cur_oh[i])
                    begin
                        slot_next[i] = ST_TERMINATED;
                    end
                end
            end
            CMD_UNBLOCK:
            begin
                if (unblock_ok)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (i < 16 && 4'(i) == tslot_reg)
                        begin
                            slot_next[i] = ST_READY;
                        end
                    end
                end
                else
                begin
                    status_next = STATUS_IGNORED;
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
        cur_out_next  = cur_next;
        cur_slot_next = 4'(cur_out_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= (i == 0) ? ST_RUNNING : ST_EMPTY;
            end
            cur_reg <= '0;
        end
        else if (ctl.commit)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            tslot_reg <= task_slot;
        end
        if (ctl.commit)
        begin
            cur_slot_reg <= cur_slot_next;
            new_slot_reg <= new_slot_next;
            status_reg   <= status_next;
        end
    end

    assign current_slot = cur_slot_reg;
    assign new_slot     = new_slot_reg;
    assign status       = status_reg;

endmodule

[hw/rtl/round_robin_task_scheduler.sv]
`timescale 1ns / 1ps
// An accepted word is captured, then committed once the result register
// is free; no new word is taken until it commits. The two-level slot search
// registers the per-group first hit, then does group select and commit.
// A pending result does not block intake; commit waits while it is stalled.
// Reset (async, active low): slot 0 running, all others empty, current 0.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: round-robin task slot scheduler
// Handles tick, create, block, exit and unblock events on a slot table.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [3:0] task_slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] current_slot,
    output logic [3:0] new_slot,
    output logic [1:0] status
);

    rrts_cmd_t ctl;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    rrts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (cmd),
        .task_slot    (task_slot),
        .current_slot (current_slot),
        .new_slot     (new_slot),
        .status       (status)
    );

`ifndef SYNTH
    // one word in flight: intake closes right after a word is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("word accepted while another is in flight");

    // a new result only follows a word that was in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a word in flight");

    // only a successful create hands out a slot
    a_new_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DONE |-> new_slot == 4'd0)
        else $error("new_slot set on a failed event");
`endif

endmodule
